// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion helpers, clocked on the rising edge and disabled in reset.
`ifndef SYNTHESIS
`define SAC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sac assertion failed");
`define SAC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sac implication failed");
`else
`define SAC_ASSERT(label, clk, rst, prop)
`define SAC_ASSERT_IMP(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/sac_pkg.sv -----
package sac_pkg;

  localparam int CODE_BITS = 8;
  localparam int POS_W     = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
  localparam int FIELD_W   = 8;
  localparam int FS_W      = 14;
  localparam int MV_W      = 14;
  localparam int PROD_W    = CODE_BITS + FS_W;
  localparam int DIGIT_W   = 4;
  localparam int REM_W     = 10;
  localparam int REM2_W    = 7;
  localparam int NUM_STAGES = 5;

  localparam logic [CODE_BITS-1:0] CODE_ONE = {{(CODE_BITS-1){1'b0}}, 1'b1};
  localparam logic [CODE_BITS-1:0] TOP_CODE = CODE_ONE << (CODE_BITS - 1);
  localparam logic [POS_W-1:0]     TOP_POS  = POS_W'(CODE_BITS - 1);

  localparam logic [MV_W-1:0] MV_LIMIT = MV_W'(9999);
  localparam logic [FS_W-1:0] FS_RESET = FS_W'(5000);

  localparam logic MODE_START  = 1'b0;
  localparam logic MODE_DECIDE = 1'b1;

  // Reciprocal multipliers for the decimal split; exact over 0..9999.
  localparam int THOU_MUL = 8389;
  localparam int THOU_SH  = 23;
  localparam int HUND_MUL = 41;
  localparam int HUND_SH  = 12;
  localparam int TENS_MUL = 205;
  localparam int TENS_SH  = 11;

  typedef struct packed {
    logic [FIELD_W-1:0]   trial_code;
    logic                 trigger;
    logic                 busy;
    logic                 done;
    logic [FIELD_W-1:0]   result_code;
    logic [CODE_BITS-1:0] code;
  } sac_event_t;

  typedef struct packed {
    sac_event_t         evt;
    logic [PROD_W-1:0]  prod;
    logic [MV_W-1:0]    mv;
    logic [REM_W-1:0]   rem;
    logic [DIGIT_W-1:0] d_thou;
    logic [DIGIT_W-1:0] d_hund;
    logic [DIGIT_W-1:0] d_tens;
    logic [DIGIT_W-1:0] d_ones;
  } sac_item_t;

  function automatic logic [MV_W-1:0] thou_weight(input logic [DIGIT_W-1:0] d);
    logic [MV_W-1:0] w;
    unique case (d)
      4'd0:    w = MV_W'(0);
      4'd1:    w = MV_W'(1000);
      4'd2:    w = MV_W'(2000);
      4'd3:    w = MV_W'(3000);
      4'd4:    w = MV_W'(4000);
      4'd5:    w = MV_W'(5000);
      4'd6:    w = MV_W'(6000);
      4'd7:    w = MV_W'(7000);
      4'd8:    w = MV_W'(8000);
      4'd9:    w = MV_W'(9000);
      default: w = MV_W'(0);
    endcase
    return w;
  endfunction

  function automatic logic [REM_W-1:0] hund_weight(input logic [DIGIT_W-1:0] d);
    logic [REM_W-1:0] w;
    unique case (d)
      4'd0:    w = REM_W'(0);
      4'd1:    w = REM_W'(100);
      4'd2:    w = REM_W'(200);
      4'd3:    w = REM_W'(300);
      4'd4:    w = REM_W'(400);
      4'd5:    w = REM_W'(500);
      4'd6:    w = REM_W'(600);
      4'd7:    w = REM_W'(700);
      4'd8:    w = REM_W'(800);
      4'd9:    w = REM_W'(900);
      default: w = REM_W'(0);
    endcase
    return w;
  endfunction

  function automatic logic [REM2_W-1:0] tens_weight(input logic [DIGIT_W-1:0] d);
    logic [REM2_W-1:0] w;
    unique case (d)
      4'd0:    w = REM2_W'(0);
      4'd1:    w = REM2_W'(10);
      4'd2:    w = REM2_W'(20);
      4'd3:    w = REM2_W'(30);
      4'd4:    w = REM2_W'(40);
      4'd5:    w = REM2_W'(50);
      4'd6:    w = REM2_W'(60);
      4'd7:    w = REM2_W'(70);
      4'd8:    w = REM2_W'(80);
      4'd9:    w = REM2_W'(90);
      default: w = REM2_W'(0);
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/sac_seq.sv -----
module sac_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                mode,
  input  logic                comp_high,
  input  logic                skip,
  output sac_pkg::sac_event_t ev
);
  import sac_pkg::*;

  logic [CODE_BITS-1:0] approx_code;
  logic [CODE_BITS-1:0] approx_code_next;
  logic [POS_W-1:0]     bit_position;
  logic [POS_W-1:0]     bit_position_next;
  logic                 converting;
  logic                 converting_next;
  logic [POS_W-1:0]     pos_cur;
  logic [CODE_BITS-1:0] kept;

  always_comb begin
    approx_code_next  = approx_code;
    bit_position_next = bit_position;
    converting_next   = converting;
    ev                = '0;

    // Positions past the top bit cannot be produced here, but are folded back anyway.
    pos_cur = (int'(bit_position) >= CODE_BITS) ? TOP_POS : bit_position;
    kept    = comp_high ? approx_code : (approx_code & ~(CODE_ONE << pos_cur));

    priority if (mode == MODE_START) begin
      approx_code_next  = TOP_CODE;
      bit_position_next = TOP_POS;
      converting_next   = !skip;
      ev.trial_code     = FIELD_W'(TOP_CODE);
      ev.trigger        = 1'b1;
      ev.busy           = !skip;
      ev.done           = skip;
      ev.result_code    = skip ? FIELD_W'(TOP_CODE) : '0;
      ev.code           = TOP_CODE;
    end else if (!converting) begin
      ev.trial_code = FIELD_W'(approx_code);
      ev.code       = approx_code;
    end else if (pos_cur != '0) begin
      bit_position_next = pos_cur - 1'b1;
      approx_code_next  = kept | (CODE_ONE << (pos_cur - 1'b1));
      ev.trial_code     = FIELD_W'(approx_code_next);
      ev.busy           = 1'b1;
      ev.code           = approx_code_next;
    end else begin
      approx_code_next  = kept;
      bit_position_next = TOP_POS;
      converting_next   = 1'b0;
      ev.trial_code     = FIELD_W'(kept);
      ev.done           = 1'b1;
      ev.result_code    = FIELD_W'(kept);
      ev.code           = kept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      approx_code  <= '0;
      bit_position <= TOP_POS;
      converting   <= 1'b0;
    end else if (accept) begin
      approx_code  <= approx_code_next;
      bit_position <= bit_position_next;
      converting   <= converting_next;
    end
  end

endmodule

// ----- hdl/sac_conv.sv -----
`include "assert_macros.svh"

module sac_conv (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sac_pkg::sac_event_t      ev,
  input  logic [sac_pkg::FS_W-1:0] full_scale,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sac_pkg::sac_item_t       res
);
  import sac_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] stage_ready;
  sac_item_t             stage      [NUM_STAGES];
  sac_item_t             stage_next [NUM_STAGES];

  logic [MV_W-1:0]       prod_hi;
  logic [MV_W-1:0]       mv_sat;
  logic [27:0]           thou_prod;
  logic [REM_W-1:0]      rem1;
  logic [15:0]           hund_prod;
  logic [REM2_W-1:0]     rem2;
  logic [15:0]           tens_prod;

  // A stage moves when it is empty or its successor moves.
  always_comb begin
    stage_ready[NUM_STAGES-1] = !valid[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_ready[k] = !valid[k] || stage_ready[k+1];
    end
  end

  assign in_ready  = stage_ready[0];
  assign out_valid = valid[NUM_STAGES-1];
  assign res       = stage[NUM_STAGES-1];

  always_comb begin
    stage_next[0]     = '0;
    stage_next[0].evt = ev;

    stage_next[1]      = stage[0];
    stage_next[1].prod = PROD_W'(stage[0].evt.code) * PROD_W'(full_scale);

    // Saturate, forcing zero for items that are not done, then pull the thousands digit with a reciprocal multiply.
    prod_hi   = stage[1].prod[PROD_W-1:CODE_BITS];
    mv_sat    = !stage[1].evt.done ? '0 : ((prod_hi > MV_LIMIT) ? MV_LIMIT : prod_hi);
    thou_prod = 28'(mv_sat) * 28'(THOU_MUL);
    stage_next[2]        = stage[1];
    stage_next[2].mv     = mv_sat;
    stage_next[2].d_thou = thou_prod[THOU_SH +: DIGIT_W];

    rem1      = REM_W'(stage[2].mv - thou_weight(stage[2].d_thou));
    hund_prod = 16'(rem1) * 16'(HUND_MUL);
    stage_next[3]        = stage[2];
    stage_next[3].rem    = rem1;
    stage_next[3].d_hund = hund_prod[HUND_SH +: DIGIT_W];

    rem2      = REM2_W'(stage[3].rem - hund_weight(stage[3].d_hund));
    tens_prod = 16'(rem2) * 16'(TENS_MUL);
    stage_next[4]        = stage[3];
    stage_next[4].d_tens = tens_prod[TENS_SH +: DIGIT_W];
    stage_next[4].d_ones = DIGIT_W'(rem2 - tens_weight(tens_prod[TENS_SH +: DIGIT_W]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (stage_ready[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stage_ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (stage_ready[k]) begin
        stage[k] <= stage_next[k];
      end
    end
  end

  `SAC_ASSERT_IMP(a_done_code_match, clk, rst, out_valid && res.evt.done, res.evt.trial_code == res.evt.result_code)
  `SAC_ASSERT_IMP(a_idle_fields_zero, clk, rst, out_valid && !res.evt.done, (res.mv == '0) && (res.evt.result_code == '0))
  `SAC_ASSERT_IMP(a_mv_limit, clk, rst, out_valid, res.mv <= MV_LIMIT)
  `SAC_ASSERT_IMP(a_digits_sum, clk, rst, out_valid, (MV_W'(res.d_thou) * MV_W'(1000) + MV_W'(res.d_hund) * MV_W'(100) + MV_W'(res.d_tens) * MV_W'(10) + MV_W'(res.d_ones)) == res.mv)
  `SAC_ASSERT_IMP(a_not_busy_and_done, clk, rst, out_valid, !(res.evt.busy && res.evt.done))

endmodule

// ----- hdl/sar_adc_control_to_bcd_mv_top.sv -----
// Successive-approximation controller with millivolt and BCD readout. Every
// request yields exactly one result, in order. A start request (mode 0) raises
// trigger and drives the top bit as trial code; each decision request (mode 1)
// keeps or clears the bit on trial and sets the next lower one, and the eighth
// decision reports the final code, its value in millivolts (code times
// full_scale_mv over 256, truncated, capped at 9999) and four BCD digits. A
// request can be taken every cycle while the result side does not stall; its
// result passes through the five-stage pipeline (request register, product,
// saturation and thousands digit, hundreds digit, tens and ones digits in the
// result register). A stalled result side holds up to five requests before
// the request side stalls. full_scale_mv resets to 5000; the user must write it
// only while no request is in flight, as the block does not enforce this.
module sar_adc_control_to_bcd_mv_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        mode,
  input  logic                        comp_high,
  input  logic                        skip,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sac_pkg::FS_W-1:0]    full_scale_mv,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [sac_pkg::FIELD_W-1:0] trial_code,
  output logic                        trigger,
  output logic                        busy_res,
  output logic                        done_res,
  output logic [sac_pkg::FIELD_W-1:0] result_code,
  output logic [sac_pkg::MV_W-1:0]    millivolts,
  output logic [sac_pkg::DIGIT_W-1:0] digit_thousands,
  output logic [sac_pkg::DIGIT_W-1:0] digit_hundreds,
  output logic [sac_pkg::DIGIT_W-1:0] digit_tens,
  output logic [sac_pkg::DIGIT_W-1:0] digit_ones
);
  import sac_pkg::*;

  logic            accept;
  logic            conv_ready;
  logic [FS_W-1:0] full_scale;
  sac_event_t      ev;
  sac_item_t       res;

  assign cfg_ready = 1'b1;
  assign req_stall = !conv_ready;
  assign accept    = req_valid && conv_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      full_scale <= full_scale_mv;
    end
  end

  sac_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (mode),
    .comp_high (comp_high),
    .skip      (skip),
    .ev        (ev)
  );

  sac_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .in_ready   (conv_ready),
    .ev         (ev),
    .full_scale (full_scale),
    .out_valid  (res_valid),
    .out_stall  (res_stall),
    .res        (res)
  );

  assign trial_code      = res.evt.trial_code;
  assign trigger         = res.evt.trigger;
  assign busy_res        = res.evt.busy;
  assign done_res        = res.evt.done;
  assign result_code     = res.evt.result_code;
  assign millivolts      = res.mv;
  assign digit_thousands = res.d_thou;
  assign digit_hundreds  = res.d_hund;
  assign digit_tens      = res.d_tens;
  assign digit_ones      = res.d_ones;

endmodule

// ----- bench/sar_adc_control_to_bcd_mv_top_tb.sv -----
module sar_adc_control_to_bcd_mv_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sac_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 200;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [FIELD_W-1:0] trial_code;
    logic               trigger;
    logic               busy;
    logic               done;
    logic [FIELD_W-1:0] result_code;
    logic [MV_W-1:0]    mv;
    logic [DIGIT_W-1:0] thou;
    logic [DIGIT_W-1:0] hund;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
  } conversion_reading_t;

  class mv_scoreboard;
    conversion_reading_t expected_readings[$];
    logic [CODE_BITS-1:0] code;
    logic [POS_W-1:0]     pos;
    bit                   converting;
    logic [FS_W-1:0]      full_scale;
    int                   mismatches;

    function new();
      code       = '0;
      pos        = TOP_POS;
      converting = 1'b0;
      full_scale = FS_RESET;
      mismatches = 0;
    endfunction

    function void set_full_scale(logic [FS_W-1:0] v);
      full_scale = v;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    function conversion_reading_t busy_reading(logic trig, logic busy);
      conversion_reading_t r;
      r            = '0;
      r.trial_code = code[FIELD_W-1:0];
      r.trigger    = trig;
      r.busy       = busy;
      return r;
    endfunction

    // Scaling is code * full_scale / 2^CODE_BITS, truncated, capped at the
    // four-digit limit.
    function conversion_reading_t finished_reading(logic trig);
      conversion_reading_t r;
      logic [PROD_W-1:0] prod;
      int unsigned mv;
      prod = (PROD_W'(code) * PROD_W'(full_scale)) >> CODE_BITS;
      mv   = (prod > PROD_W'(MV_LIMIT)) ? 32'(MV_LIMIT) : 32'(prod);
      r             = '0;
      r.trial_code  = code[FIELD_W-1:0];
      r.trigger     = trig;
      r.done        = 1'b1;
      r.result_code = code[FIELD_W-1:0];
      r.mv          = MV_W'(mv);
      r.thou        = DIGIT_W'(mv / 1000);
      r.hund        = DIGIT_W'((mv / 100) % 10);
      r.tens        = DIGIT_W'((mv / 10) % 10);
      r.ones        = DIGIT_W'(mv % 10);
      return r;
    endfunction

    function void note_request(logic m, logic c, logic s);
      conversion_reading_t r;
      if (m == MODE_START) begin
        code = TOP_CODE;
        pos  = TOP_POS;
        if (s) begin
          converting = 1'b0;
          r = finished_reading(1'b1);
        end else begin
          converting = 1'b1;
          r = busy_reading(1'b1, 1'b1);
        end
      end else if (!converting) begin
        r = busy_reading(1'b0, 1'b0);
      end else begin
        if (!c) code[pos] = 1'b0;
        if (pos != 0) begin
          pos = pos - 1'b1;
          code[pos] = 1'b1;
          r = busy_reading(1'b0, 1'b1);
        end else begin
          converting = 1'b0;
          pos = TOP_POS;
          r = finished_reading(1'b0);
        end
      end
      expected_readings.push_back(r);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%0t: %s", $realtime, what);
    endfunction

    function void field_check(string name, int unsigned e, int unsigned a);
      if (e != a) flag($sformatf("%s expected %0d got %0d", name, e, a));
    endfunction

    function void check_result(conversion_reading_t got);
      conversion_reading_t e;
      if (expected_readings.size() == 0) begin
        flag($sformatf("result with no request outstanding: %p", got));
        return;
      end
      e = expected_readings.pop_front();
      field_check("trial_code", e.trial_code, got.trial_code);
      field_check("trigger", e.trigger, got.trigger);
      field_check("busy_res", e.busy, got.busy);
      field_check("done_res", e.done, got.done);
      field_check("result_code", e.result_code, got.result_code);
      field_check("millivolts", e.mv, got.mv);
      field_check("digit_thousands", e.thou, got.thou);
      field_check("digit_hundreds", e.hund, got.hund);
      field_check("digit_tens", e.tens, got.tens);
      field_check("digit_ones", e.ones, got.ones);
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic                mode;
  logic                comp_high;
  logic                skip;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [FS_W-1:0]     full_scale_mv;
  logic                res_valid;
  logic                res_stall;
  logic [FIELD_W-1:0]  trial_code;
  logic                trigger;
  logic                busy_res;
  logic                done_res;
  logic [FIELD_W-1:0]  result_code;
  logic [MV_W-1:0]     millivolts;
  logic [DIGIT_W-1:0]  digit_thousands;
  logic [DIGIT_W-1:0]  digit_hundreds;
  logic [DIGIT_W-1:0]  digit_tens;
  logic [DIGIT_W-1:0]  digit_ones;

  mv_scoreboard sb = new();
  bit  no_gaps;
  bit  hold_request;
  bit  hold_active;
  int  cycles;

  sar_adc_control_to_bcd_mv_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sar_adc_control_to_bcd_mv_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_full_scale(full_scale_mv);
      if (req_valid && !req_stall) sb.note_request(mode, comp_high, skip);
      if (res_valid && !res_stall)
        sb.check_result({trial_code, trigger, busy_res, done_res, result_code, millivolts,
                         digit_thousands, digit_hundreds, digit_tens, digit_ones});
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  // Result side: random stalls, an occasional long free stretch, and one long
  // hold-off on request from the stimulus so the pipeline backs up.
  initial begin
    res_stall <= 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
      end else if (pick_gap() > 0) begin
        res_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
      end
      res_stall <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat (50) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  task automatic send_request(input logic m, input logic c, input logic s);
    int gap;
    req_valid <= 1'b1;
    mode      <= m;
    comp_high <= c;
    skip      <= s;
    do @(posedge clk); while (req_stall);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_conversion(input logic s, input logic [CODE_BITS-1:0] decisions);
    send_request(MODE_START, 1'($urandom), s);
    if (!s) begin
      for (int i = CODE_BITS - 1; i >= 0; i--)
        send_request(MODE_DECIDE, decisions[i], 1'($urandom));
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_full_scale(input logic [FS_W-1:0] v);
    cfg_valid     <= 1'b1;
    full_scale_mv <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly complete conversions with random decisions; the rest are
  // abandoned conversions and stray decisions.
  task automatic run_random(input int target);
    int counted;
    int r;
    int n;
    counted = 0;
    run_conversion(1'b0, '1);
    while (counted < target) begin
      r = int'($urandom_range(0, 99));
      if (r < 80) begin
        if ($urandom_range(0, 7) == 0) begin
          run_conversion(1'b1, '0);
          counted += 1;
        end else begin
          run_conversion(1'b0, CODE_BITS'($urandom));
          counted += CODE_BITS + 1;
        end
      end else if (r < 90) begin
        n = int'($urandom_range(1, CODE_BITS - 1));
        send_request(MODE_START, 1'($urandom), 1'b0);
        repeat (n) send_request(MODE_DECIDE, 1'($urandom), 1'($urandom));
        counted += n + 1;
      end else begin
        repeat ($urandom_range(1, 3)) send_request(MODE_DECIDE, 1'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    req_valid     <= 1'b0;
    mode          <= MODE_START;
    comp_high     <= 1'b0;
    skip          <= 1'b0;
    cfg_valid     <= 1'b0;
    full_scale_mv <= FS_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: stray decision after reset, all-ones and all-zeros codes,
    // skip, stray decision after skip, and a restart during a conversion.
    send_request(MODE_DECIDE, 1'b1, 1'b0);
    run_conversion(1'b0, '1);
    run_conversion(1'b0, '0);
    run_conversion(1'b1, '0);
    send_request(MODE_DECIDE, 1'b1, 1'b1);
    send_request(MODE_START, 1'b1, 1'b0);
    send_request(MODE_DECIDE, 1'b0, 1'b0);
    send_request(MODE_DECIDE, 1'b1, 1'b0);
    send_request(MODE_START, 1'b0, 1'b1);
    run_random(150);
    drain();

    write_full_scale(FS_W'(9999));
    hold_request = 1'b1;
    wait (hold_active);
    no_gaps = 1'b1;
    repeat (6) run_conversion(1'b0, CODE_BITS'($urandom));
    no_gaps = 1'b0;
    run_random(150);
    drain();

    write_full_scale(FS_W'(1));
    run_random(180);
    drain();
    write_full_scale('0);
    run_random(180);
    drain();
    write_full_scale('1);
    run_random(180);
    drain();
    write_full_scale(FS_W'($urandom_range(1, 9999)));
    run_random(180);
    drain();
    write_full_scale(FS_W'($urandom));
    run_random(180);
    drain();
    write_full_scale(FS_RESET);
    run_random(180);
    drain();

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("sar_adc_control_to_bcd_mv_top verification clean");
    end else begin
      $display("sar_adc_control_to_bcd_mv_top verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/sac_pkg.sv
hdl/sac_seq.sv
hdl/sac_conv.sv
hdl/sar_adc_control_to_bcd_mv_top.sv
bench/sar_adc_control_to_bcd_mv_top_tb.sv
